>>> sv/locd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the cache directory.
package locd_pkg;

  localparam int LINES    = 10;
  localparam int KEY_BITS = 64;
  localparam int MAX_SIZE = 102400;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 17;
  localparam int LINE_W  = 6;
  localparam int STAMP_W = 32;
  localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_req;
    logic step_scan;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/lru_object_cache_directory.sv
// Top level of the fully associative LRU object cache directory.
// An insert scans all entries, one per cycle, for the first free entry or the one with the
// oldest use stamp. A lookup scans only up to the first valid matching key, so an early hit
// ends the scan sooner. The update state then updates the entry and the use clock, the finish
// state loads the result register once it is free, and the result can then transfer. Inserts
// larger than the maximum object size end the scan at once, leave the directory unchanged and
// return zeros. A new request is taken once the previous result has been loaded, even if it
// has not yet been taken.
module lru_object_cache_directory import locd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [KEY_W-1:0]  key,
  input  logic [SIZE_W-1:0] object_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic [LINE_W-1:0] line_index,
  output logic [SIZE_W-1:0] found_size,
  output logic              evicted
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  locd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  locd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .key         (key),
    .object_size (object_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .line_index  (line_index),
    .found_size  (found_size),
    .evicted     (evicted)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a previous one was in progress");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result reports both a hit and an eviction");

  a_miss_size_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (found_size == '0))
    else $error("nonzero size reported without a hit");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(line_index) < 32'(LINES)))
    else $error("line index outside the directory");

endmodule

>>> sv/locd_ctrl.sv
// Controller state machine that sequences accept, scan, update and result delivery.
module locd_ctrl import locd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      ST_SCAN: begin
        cmd.step_scan = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> sv/locd_dp.sv
// Datapath holding the directory entries, the use clock, the scan unit and the result register.
module locd_dp import locd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic              mode,
  input  logic [KEY_W-1:0]  key,
  input  logic [SIZE_W-1:0] object_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic [LINE_W-1:0] line_index,
  output logic [SIZE_W-1:0] found_size,
  output logic              evicted
);

  logic [LINES-1:0]    ent_valid;
  logic [KEY_BITS-1:0] ent_key   [LINES];
  logic [SIZE_W-1:0]   ent_size  [LINES];
  logic [STAMP_W-1:0]  ent_stamp [LINES];
  logic [STAMP_W-1:0]  use_clock;

  logic                req_mode;
  logic [KEY_BITS-1:0] req_key;
  logic [SIZE_W-1:0]   req_size;

  logic [IDX_W-1:0]    scan_idx;
  logic                found;
  logic [IDX_W-1:0]    found_idx;
  logic                have_free;
  logic [IDX_W-1:0]    free_idx;
  logic [STAMP_W-1:0]  best_stamp;
  logic [IDX_W-1:0]    best_idx;

  logic                res_hit;
  logic [IDX_W-1:0]    res_idx;
  logic [SIZE_W-1:0]   res_size;
  logic                res_evicted;

  logic                oversize;
  logic                cur_match;
  logic                scan_last;
  logic [IDX_W-1:0]    victim;
  logic                do_hit;
  logic                do_fill;

  assign oversize  = (req_mode == MODE_INSERT) && (32'(req_size) > 32'(MAX_SIZE));
  assign cur_match = ent_valid[scan_idx] && (ent_key[scan_idx] == req_key);
  assign scan_last = (scan_idx == IDX_W'(LINES - 1));
  assign victim    = have_free ? free_idx : best_idx;
  assign do_hit    = cmd.update && (req_mode == MODE_LOOKUP) && found;
  assign do_fill   = cmd.update && (req_mode == MODE_INSERT) && !oversize;

  assign status.scan_done = oversize || scan_last ||
                            ((req_mode == MODE_LOOKUP) && cur_match);
  assign status.out_free  = !out_valid || !out_stall;

  // Control state: valid bits, use clock and the result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      use_clock <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_hit) begin
        use_clock <= use_clock + STAMP_W'(2);
      end else if (do_fill) begin
        use_clock         <= use_clock + STAMP_W'(1);
        ent_valid[victim] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: request, scan bookkeeping, entry contents and results.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode  <= mode;
      req_key   <= key[KEY_BITS-1:0];
      req_size  <= object_size;
      scan_idx  <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end
    if (cmd.step_scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if ((req_mode == MODE_LOOKUP) && cur_match) begin
        found     <= 1'b1;
        found_idx <= scan_idx;
      end
      if (!ent_valid[scan_idx] && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= scan_idx;
      end
      if ((scan_idx == '0) || (ent_stamp[scan_idx] < best_stamp)) begin
        best_stamp <= ent_stamp[scan_idx];
        best_idx   <= scan_idx;
      end
    end
    if (cmd.update) begin
      res_hit     <= 1'b0;
      res_idx     <= '0;
      res_size    <= '0;
      res_evicted <= 1'b0;
      if (do_hit) begin
        ent_stamp[found_idx] <= use_clock + STAMP_W'(1);
        res_hit              <= 1'b1;
        res_idx              <= found_idx;
        res_size             <= ent_size[found_idx];
      end else if (do_fill) begin
        ent_stamp[victim] <= use_clock + STAMP_W'(1);
        ent_key[victim]   <= req_key;
        ent_size[victim]  <= req_size;
        res_idx           <= victim;
        res_evicted       <= !have_free;
      end
    end
    if (cmd.load_out) begin
      hit        <= res_hit;
      line_index <= LINE_W'(res_idx);
      found_size <= res_size;
      evicted    <= res_evicted;
    end
  end

endmodule

>>> bench/tb.sv
// Self-checking testbench for the LRU object cache directory: directed and random requests.
module tb;
  import locd_pkg::*;

  localparam int POOL_KEYS      = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] line;
    logic [SIZE_W-1:0] size;
    logic              evicted;
  } dir_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              mode;
  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] object_size;
  logic              out_valid;
  logic              out_stall;
  logic              hit;
  logic [LINE_W-1:0] line_index;
  logic [SIZE_W-1:0] found_size;
  logic              evicted;

  logic               dir_valid [LINES];
  logic [KEY_W-1:0]   dir_key   [LINES];
  logic [SIZE_W-1:0]  dir_size  [LINES];
  logic [STAMP_W-1:0] dir_stamp [LINES];
  logic [STAMP_W-1:0] dir_clock;

  dir_result_t       pending_results[$];
  logic [KEY_W-1:0]  key_pool [POOL_KEYS];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int mismatches;
  int n_lookups;
  int n_hits;
  int n_inserts;
  int n_evictions;
  int n_oversized;

  lru_object_cache_directory uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .object_size(object_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .line_index(line_index), .found_size(found_size), .evicted(evicted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic dir_result_t apply_request(input logic m, input logic [KEY_W-1:0] k,
                                                input logic [SIZE_W-1:0] s);
    dir_result_t r;
    int victim;
    r = '0;
    victim = -1;
    if (m == MODE_LOOKUP) begin
      n_lookups++;
      for (int i = 0; i < LINES; i++) begin
        if (victim < 0 && dir_valid[i] && dir_key[i] == k) victim = i;
      end
      if (victim >= 0) begin
        dir_stamp[victim] = dir_clock + 32'd1;
        dir_clock = dir_clock + 32'd2;
        r.hit = 1'b1;
        r.line = LINE_W'(victim);
        r.size = dir_size[victim];
        n_hits++;
      end
    end else if (s > MAX_SIZE) begin
      n_oversized++;
    end else begin
      n_inserts++;
      for (int i = 0; i < LINES; i++) begin
        if (victim < 0 && !dir_valid[i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < LINES; i++) begin
          if (dir_stamp[i] < dir_stamp[victim]) victim = i;
        end
        r.evicted = 1'b1;
        n_evictions++;
      end
      dir_clock = dir_clock + 32'd1;
      dir_stamp[victim] = dir_clock;
      dir_key[victim] = k;
      dir_size[victim] = s;
      dir_valid[victim] = 1'b1;
      r.line = LINE_W'(victim);
    end
    return r;
  endfunction

  task automatic send_request(input logic m, input logic [KEY_W-1:0] k,
                              input logic [SIZE_W-1:0] s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    object_size <= s;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(m, k, s));
  endtask

  task automatic send_random_request();
    int r;
    int sz;
    logic m;
    logic [KEY_W-1:0] k;
    logic [SIZE_W-1:0] s;
    r = $urandom_range(99);
    sz = $urandom_range(9);
    m = (r < 50) ? MODE_LOOKUP : MODE_INSERT;
    k = key_pool[$urandom_range(POOL_KEYS - 1)];
    if (sz == 0) s = '0;
    else if (sz == 1) s = SIZE_W'(MAX_SIZE);
    else if (sz == 2) s = SIZE_W'($urandom_range(17'h1FFFF, MAX_SIZE + 1));
    else s = SIZE_W'($urandom_range(MAX_SIZE));
    if (r >= 92) begin
      k = {$urandom, $urandom};
      s = SIZE_W'($urandom_range(17'h1FFFF));
    end
    send_request(m, k, s);
  endtask

  task automatic test_empty_and_limits();
    send_request(MODE_LOOKUP, '0, '0);
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_INSERT, '1, SIZE_W'(MAX_SIZE));
    send_request(MODE_INSERT, 64'h1234, SIZE_W'(MAX_SIZE + 1));
    send_request(MODE_INSERT, 64'h1234, '1);
    send_request(MODE_LOOKUP, 64'h1234, '0);
    send_request(MODE_LOOKUP, '1, '1);
    send_request(MODE_LOOKUP, '0, '0);
  endtask

  task automatic test_fill_and_evict();
    logic [KEY_W-1:0] base;
    base = 64'hA5A5_0000_0000_0100;
    for (int i = 0; i < 8; i++) send_request(MODE_INSERT, base + i, SIZE_W'(i * 1000 + 7));
    send_request(MODE_INSERT, base + 8, SIZE_W'(4242));
    send_request(MODE_LOOKUP, base + 1, '0);
    send_request(MODE_INSERT, base + 1, SIZE_W'(99));
    send_request(MODE_LOOKUP, base + 1, '1);
    send_request(MODE_INSERT, base + 9, SIZE_W'(1));
  endtask

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random_request();
  endtask

  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (10) send_random_request();
  endtask

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_seen != hold_requests) begin
        hold_seen++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    dir_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: hit=%0d line=%0d size=%0d evicted=%0d",
                   hit, line_index, found_size, evicted);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit || line_index !== want.line || found_size !== want.size ||
            evicted !== want.evicted) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected hit=%0d line=%0d size=%0d evicted=%0d, got %0d %0d %0d %0d",
                     want.hit, want.line, want.size, want.evicted,
                     hit, line_index, found_size, evicted);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= MODE_LOOKUP;
    key <= '0;
    object_size <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    mismatches = 0;
    n_lookups = 0;
    n_hits = 0;
    n_inserts = 0;
    n_evictions = 0;
    n_oversized = 0;
    dir_clock = '0;
    for (int i = 0; i < LINES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i] = '0;
      dir_size[i] = '0;
      dir_stamp[i] = '0;
    end
    for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_limits();
    test_fill_and_evict();
    test_random_traffic(200, 30, 87);
    test_random_traffic(200, 87, 30);
    test_receiver_hold_off();
    test_random_traffic(200, 0, 0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d lookups (%0d hits) and %0d inserts (%0d evictions), %0d oversized.",
             n_lookups, n_hits, n_inserts, n_evictions, n_oversized);
    $display("Traffic ran with sender-heavy, receiver-heavy and no idling, plus one long hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching results.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/locd_pkg.sv
sv/locd_ctrl.sv
sv/locd_dp.sv
sv/lru_object_cache_directory.sv
bench/tb.sv
